[rtl/assert_macros.svh]
// assertion macros used by the sorter top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, masked while reset is asserted
`define SDOS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked property that also covers the reset cycles
`define SDOS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/sdos_pkg.sv]
// package: sizes, key entry type, memory request type and key compare
`timescale 1ns / 1ps

package sdos_pkg;

  localparam int MAX_ENTITIES   = 64;
  localparam int ADDR_W         = $clog2(MAX_ENTITIES);
  localparam int CNT_W          = $clog2(MAX_ENTITIES + 1);
  localparam int Y_POS_W        = 24;
  localparam int Z_ORDER_W      = 16;
  localparam int ENTITY_INDEX_W = 6;

  // one sorted slot: both keys and the arrival index
  typedef struct packed {
    logic signed [Y_POS_W-1:0]   y_pos;
    logic signed [Z_ORDER_W-1:0] z_order;
    logic [ADDR_W-1:0]           idx;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // key memory access for one cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // true when the stored entry must move up past the new one
  function automatic logic goes_after(entry_t stored, entry_t fresh);
    logic res;
    res = (stored.y_pos > fresh.y_pos) ||
          ((stored.y_pos == fresh.y_pos) && (stored.z_order > fresh.z_order));
    return res;
  endfunction

endpackage

[rtl/sdos_ifs.sv]
// channel interfaces: entity input and sorted index output
`timescale 1ns / 1ps

interface sdos_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    active;
  logic signed [sdos_pkg::Y_POS_W-1:0]     y_pos;
  logic signed [sdos_pkg::Z_ORDER_W-1:0]   z_order;
  logic                                    last_entity;

  modport source (output valid, active, y_pos, z_order, last_entity, input ready);
  modport sink   (input valid, active, y_pos, z_order, last_entity, output ready);
endinterface

interface sdos_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [sdos_pkg::ENTITY_INDEX_W-1:0]   entity_index;
  logic                                  last_of_run;
  logic                                  empty_set;

  modport source (output valid, entity_index, last_of_run, empty_set, input ready);
  modport sink   (input valid, entity_index, last_of_run, empty_set, output ready);
endinterface

[rtl/sdos_ram.sv]
// generic single write, single read port ram with registered read data
`timescale 1ns / 1ps

module sdos_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/sdos_ctrl.sv]
// insertion and readout sequencer with output register
`timescale 1ns / 1ps

module sdos_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  sdos_in_if.sink             in_ch,
  sdos_out_if.source          out_ch,
  output sdos_pkg::ram_req_t  ram_req,
  input  sdos_pkg::entry_t    rd_entry
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_SHIFT    = 5'b00010,
    ST_PLACE    = 5'b00100,
    ST_EMIT_RD  = 5'b01000,
    ST_EMIT_OUT = 5'b10000
  } state_t;

  localparam logic [sdos_pkg::CNT_W-1:0] MAX_CNT =
    sdos_pkg::CNT_W'(sdos_pkg::MAX_ENTITIES);

  state_t                          state_r, state_nxt;
  logic [sdos_pkg::CNT_W-1:0]      arrival_r, arrival_nxt;
  logic [sdos_pkg::CNT_W-1:0]      active_r, active_nxt;
  logic [sdos_pkg::ADDR_W-1:0]     pos_r, pos_nxt;
  logic [sdos_pkg::ADDR_W-1:0]     k_r, k_nxt;
  logic                            last_r, last_nxt;
  sdos_pkg::entry_t                new_r, new_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [sdos_pkg::ENTITY_INDEX_W-1:0] out_idx_r;
  logic                            out_last_r;
  logic                            out_empty_r;

  logic                            in_fire;
  logic                            store;
  logic                            out_free;
  logic                            out_load;
  logic                            emit_empty;
  logic                            emit_final;
  sdos_pkg::entry_t                in_entry;
  state_t                          finish_state;

  // input transaction and decode
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign store       = in_ch.active && (arrival_r < MAX_CNT) && (active_r < MAX_CNT);
  assign in_entry    = '{y_pos:   in_ch.y_pos,
                         z_order: in_ch.z_order,
                         idx:     arrival_r[sdos_pkg::ADDR_W-1:0]};
  assign finish_state = last_r ? ST_EMIT_RD : ST_IDLE;

  // readout status
  assign out_free   = !out_valid_r || out_ch.ready;
  assign emit_empty = (active_r == '0);
  assign emit_final = emit_empty ||
                      ((sdos_pkg::CNT_W'(k_r) + sdos_pkg::CNT_W'(1)) == active_r);
  assign out_load   = (state_r == ST_EMIT_OUT) && out_free;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    arrival_nxt   = arrival_r;
    active_nxt    = active_r;
    pos_nxt       = pos_r;
    k_nxt         = k_r;
    last_nxt      = last_r;
    new_nxt       = new_r;
    ram_req       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          new_nxt  = in_entry;
          last_nxt = in_ch.last_entity;
          if (arrival_r < MAX_CNT) begin
            arrival_nxt = arrival_r + sdos_pkg::CNT_W'(1);
          end
          if (store) begin
            active_nxt = active_r + sdos_pkg::CNT_W'(1);
            if (active_r == '0) begin
              // first entry goes straight to slot zero
              ram_req.we    = 1'b1;
              ram_req.waddr = '0;
              ram_req.wdata = in_entry;
              state_nxt     = in_ch.last_entity ? ST_EMIT_RD : ST_IDLE;
            end else begin
              pos_nxt       = active_r[sdos_pkg::ADDR_W-1:0];
              ram_req.re    = 1'b1;
              ram_req.raddr = active_r[sdos_pkg::ADDR_W-1:0] - sdos_pkg::ADDR_W'(1);
              state_nxt     = ST_SHIFT;
            end
          end else if (in_ch.last_entity) begin
            state_nxt = (active_r == '0) ? ST_EMIT_OUT : ST_EMIT_RD;
          end
        end
      end
      ST_SHIFT: begin
        if (sdos_pkg::goes_after(rd_entry, new_r)) begin
          // move the slot below up by one, fetch the next one down
          ram_req.we    = 1'b1;
          ram_req.waddr = pos_r;
          ram_req.wdata = rd_entry;
          pos_nxt       = pos_r - sdos_pkg::ADDR_W'(1);
          if (pos_r == sdos_pkg::ADDR_W'(1)) begin
            state_nxt = ST_PLACE;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = pos_r - sdos_pkg::ADDR_W'(2);
          end
        end else begin
          ram_req.we    = 1'b1;
          ram_req.waddr = pos_r;
          ram_req.wdata = new_r;
          state_nxt     = finish_state;
        end
      end
      ST_PLACE: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = pos_r;
        ram_req.wdata = new_r;
        state_nxt     = finish_state;
      end
      ST_EMIT_RD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = k_r;
        state_nxt     = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (out_free) begin
          if (emit_final) begin
            arrival_nxt = '0;
            active_nxt  = '0;
            k_nxt       = '0;
            state_nxt   = ST_IDLE;
          end else begin
            k_nxt         = k_r + sdos_pkg::ADDR_W'(1);
            ram_req.re    = 1'b1;
            ram_req.raddr = k_r + sdos_pkg::ADDR_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output valid
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      arrival_r   <= '0;
      active_r    <= '0;
      pos_r       <= '0;
      k_r         <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      arrival_r   <= arrival_nxt;
      active_r    <= active_nxt;
      pos_r       <= pos_nxt;
      k_r         <= k_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    new_r <= new_nxt;
    if (out_load) begin
      out_idx_r   <= emit_empty ? '0 : sdos_pkg::ENTITY_INDEX_W'(rd_entry.idx);
      out_last_r  <= emit_final;
      out_empty_r <= emit_empty;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.entity_index = out_idx_r;
  assign out_ch.last_of_run  = out_last_r;
  assign out_ch.empty_set    = out_empty_r;

endmodule

[rtl/stable_depth_order_sorter.sv]
// top level: stable two-key depth order sorter
//
//  channel  dir  handshake      payload
//  in_ch    in   valid / ready  active, y_pos, z_order, last_entity
//  out_ch   out  valid / ready  entity_index, last_of_run, empty_set
//
// an inactive or beyond-capacity item is handled in ST_IDLE alone, as is the first stored
// entry of a run; any other active item reads the last stored slot in ST_IDLE, then moves
// past each stored entry that goes after it in ST_SHIFT, one read-compare-write on the key
// ram per cycle, and is written in ST_SHIFT or ST_PLACE
// readout after the last item: ST_EMIT_RD reads the first slot, then ST_EMIT_OUT gives
// one result per cycle while out_ch is ready; an empty set skips ST_EMIT_RD
// synchronous active-low reset clears the counters, no ram clearing pass
// in_ch is stalled during insertion and readout; out_ch stalls hold the output register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stable_depth_order_sorter (
  input  logic        clk,
  input  logic        rst_n,
  sdos_in_if.sink     in_ch,
  sdos_out_if.source  out_ch
);

  sdos_pkg::ram_req_t              ram_req;
  sdos_pkg::entry_t                rd_entry;
  logic [sdos_pkg::ENTRY_W-1:0]    rd_data;

  // sequencer
  sdos_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .ram_req  (ram_req),
    .rd_entry (rd_entry)
  );

  // sorted key and index store
  sdos_ram #(
    .WIDTH  (sdos_pkg::ENTRY_W),
    .DEPTH  (sdos_pkg::MAX_ENTITIES),
    .ADDR_W (sdos_pkg::ADDR_W)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (ram_req.we),
    .wr_addr (ram_req.waddr),
    .wr_data (ram_req.wdata),
    .rd_en   (ram_req.re),
    .rd_addr (ram_req.raddr),
    .rd_data (rd_data)
  );

  assign rd_entry = sdos_pkg::entry_t'(rd_data);

  // checks
  `SDOS_ASSERT(a_no_rw_clash, (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr), "read and write hit the same slot")
  `SDOS_ASSERT(a_waddr_range, ram_req.we |-> (ram_req.waddr <= sdos_pkg::ADDR_W'(sdos_pkg::MAX_ENTITIES - 1)), "write beyond capacity")
  `SDOS_ASSERT(a_empty_is_last, out_ch.valid |-> (!out_ch.empty_set || out_ch.last_of_run), "empty result not marked last")
  `SDOS_ASSERT_RST(a_reset_no_out, !rst_n |=> !out_ch.valid, "output valid after reset")

endmodule

[tb/sv/tb_top.sv]
// testbench for the stable two-key depth order sorter: random runs checked against a predictor
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 2 * sdos_pkg::MAX_ENTITIES + 8;
  localparam int RANDOM_ITEMS   = 270;

  // one entity record as driven on the input channel
  typedef struct {
    logic                                  active;
    logic signed [sdos_pkg::Y_POS_W-1:0]   y_pos;
    logic signed [sdos_pkg::Z_ORDER_W-1:0] z_order;
    logic                                  last_entity;
  } entity_rec_t;

  // one sorted index as seen on the result channel
  typedef struct {
    logic [sdos_pkg::ENTITY_INDEX_W-1:0] entity_index;
    logic                                last_of_run;
    logic                                empty_set;
  } sorted_result_t;

  // predicts the sorted index sequence and checks it transaction by transaction
  class order_scoreboard;
    logic signed [sdos_pkg::Y_POS_W-1:0]   pos_slot[sdos_pkg::MAX_ENTITIES];
    logic signed [sdos_pkg::Z_ORDER_W-1:0] layer_slot[sdos_pkg::MAX_ENTITIES];
    logic [sdos_pkg::ENTITY_INDEX_W-1:0]   index_slot[sdos_pkg::MAX_ENTITIES];
    int unsigned                 seen_count;
    int unsigned                 stored_count;
    sorted_result_t              expected_order_q[$];
    int unsigned                 mismatches;
    int unsigned                 results_seen;

    function new();
      seen_count   = 0;
      stored_count = 0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    // insert an accepted entity and, on the last one, queue the sorted order
    function void note_entity(entity_rec_t e);
      int unsigned    b;
      sorted_result_t r;
      if (seen_count < sdos_pkg::MAX_ENTITIES) begin
        if (e.active && stored_count < sdos_pkg::MAX_ENTITIES) begin
          b = stored_count;
          while (b > 0 && ((pos_slot[b-1] > e.y_pos) ||
                           ((pos_slot[b-1] == e.y_pos) && (layer_slot[b-1] > e.z_order)))) begin
            pos_slot[b]   = pos_slot[b-1];
            layer_slot[b] = layer_slot[b-1];
            index_slot[b] = index_slot[b-1];
            b--;
          end
          pos_slot[b]   = e.y_pos;
          layer_slot[b] = e.z_order;
          index_slot[b] = seen_count[sdos_pkg::ENTITY_INDEX_W-1:0];
          stored_count++;
        end
        seen_count++;
      end
      if (!e.last_entity) return;
      if (stored_count == 0) begin
        r.entity_index = '0;
        r.last_of_run  = 1'b1;
        r.empty_set    = 1'b1;
        expected_order_q.push_back(r);
      end else begin
        for (int unsigned k = 0; k < stored_count; k++) begin
          r.entity_index = index_slot[k];
          r.last_of_run  = (k + 1 == stored_count);
          r.empty_set    = 1'b0;
          expected_order_q.push_back(r);
        end
      end
      seen_count   = 0;
      stored_count = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    // compare one accepted result with the oldest expectation
    task check_result(logic [sdos_pkg::ENTITY_INDEX_W-1:0] idx, logic last_flag,
                      logic empty_flag);
      sorted_result_t exp_r;
      results_seen++;
      if (expected_order_q.size() == 0) begin
        report($sformatf("unexpected result %0d: index %0d last %b empty %b",
                         results_seen, idx, last_flag, empty_flag));
        return;
      end
      exp_r = expected_order_q.pop_front();
      if (idx !== exp_r.entity_index)
        report($sformatf("result %0d entity_index %0d, want %0d",
                         results_seen, idx, exp_r.entity_index));
      if (last_flag !== exp_r.last_of_run)
        report($sformatf("result %0d last_of_run %b, want %b",
                         results_seen, last_flag, exp_r.last_of_run));
      if (empty_flag !== exp_r.empty_set)
        report($sformatf("result %0d empty_set %b, want %b",
                         results_seen, empty_flag, exp_r.empty_set));
    endtask
  endclass

  logic            clk;
  logic            rst_n;
  sdos_in_if       in_ch();
  sdos_out_if      out_ch();
  order_scoreboard board;
  int unsigned     burst_left;
  int unsigned     quiet_cycles;

  stable_depth_order_sorter u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic entity_rec_t make_entity(bit act, int y, int z, bit last);
    entity_rec_t e;
    e.active      = act;
    e.y_pos       = y[sdos_pkg::Y_POS_W-1:0];
    e.z_order     = z[sdos_pkg::Z_ORDER_W-1:0];
    e.last_entity = last;
    return e;
  endfunction

  // drive one entity in bursts with random gaps, wait for its transaction
  task automatic send_entity(entity_rec_t e);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.active      <= e.active;
    in_ch.y_pos       <= e.y_pos;
    in_ch.z_order     <= e.z_order;
    in_ch.last_entity <= e.last_entity;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.note_entity(e);
  endtask

  // one run of entities ending with the last flag
  task automatic play_run(int unsigned len, int unsigned active_pct, bit narrow_keys);
    entity_rec_t e;
    int          y_choices[6];
    int          z_choices[4];
    y_choices = '{-8388608, -1, 0, 1, 256, 8388607};
    z_choices = '{-32768, -1, 0, 32767};
    for (int unsigned i = 0; i < len; i++) begin
      e.active = ($urandom_range(0, 99) < active_pct);
      if (narrow_keys) begin
        e.y_pos   = sdos_pkg::Y_POS_W'(y_choices[$urandom_range(0, 5)]);
        e.z_order = sdos_pkg::Z_ORDER_W'(z_choices[$urandom_range(0, 3)]);
      end else begin
        e.y_pos   = sdos_pkg::Y_POS_W'($urandom);
        e.z_order = sdos_pkg::Z_ORDER_W'($urandom);
      end
      e.last_entity = (i == len - 1);
      send_entity(e);
    end
  endtask

  // stimulus and end of run
  initial begin : stimulus
    int unsigned items_sent;
    int unsigned run_len;
    int unsigned pick;
    int unsigned act_pct;
    board             = new();
    burst_left        = 0;
    in_ch.valid       = 1'b0;
    in_ch.active      = 1'b0;
    in_ch.y_pos       = '0;
    in_ch.z_order     = '0;
    in_ch.last_entity = 1'b0;
    rst_n             = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty set from a lone inactive entity
    send_entity(make_entity(1'b0, 8388607, 32767, 1'b1));
    // single active entity at the lowest keys
    send_entity(make_entity(1'b1, -8388608, -32768, 1'b1));
    // extremes, full ties and an inactive entity in the middle; inactive last
    send_entity(make_entity(1'b1, 0, 0, 1'b0));
    send_entity(make_entity(1'b1, -8388608, 32767, 1'b0));
    send_entity(make_entity(1'b0, 8388607, -32768, 1'b0));
    send_entity(make_entity(1'b1, 8388607, -32768, 1'b0));
    send_entity(make_entity(1'b1, 0, 0, 1'b0));
    send_entity(make_entity(1'b1, 0, -1, 1'b0));
    send_entity(make_entity(1'b1, -1, 0, 1'b0));
    send_entity(make_entity(1'b1, 0, 0, 1'b0));
    send_entity(make_entity(1'b1, 8388607, 32767, 1'b0));
    send_entity(make_entity(1'b0, -1, -1, 1'b1));
    // several inactive entities give an empty set
    send_entity(make_entity(1'b0, 0, 0, 1'b0));
    send_entity(make_entity(1'b0, -1, -1, 1'b0));
    send_entity(make_entity(1'b0, 1, 1, 1'b1));

    // full capacity with entities beyond it
    items_sent = 15 + 68;
    play_run(68, 100, 1'b0);
    // random runs, mostly short, a few beyond capacity
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 14)
        run_len = $urandom_range(1, 10);
      else if (pick < 18)
        run_len = $urandom_range(11, 40);
      else
        run_len = $urandom_range(60, 72);
      pick = $urandom_range(0, 9);
      act_pct = (pick == 0) ? 0 : (pick == 1) ? 100 : $urandom_range(40, 95);
      play_run(run_len, act_pct, $urandom_range(0, 1));
      items_sent += run_len;
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (board.expected_order_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.expected_order_q.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

  // result side stalls on a rotating pattern, renewed now and then
  initial begin : result_stall
    logic [15:0] stall_pattern;
    int unsigned phase;
    int unsigned hold;
    out_ch.ready  = 1'b0;
    stall_pattern = '1;
    phase         = 0;
    hold          = 0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pattern = '1;
          1:       stall_pattern = 16'($urandom) | 16'h0001;
          default: stall_pattern = 16'($urandom & $urandom) |
                                   (16'h0001 << $urandom_range(0, 15));
        endcase
        hold = $urandom_range(16, 96);
      end
      hold--;
      out_ch.ready <= stall_pattern[phase];
      phase = (phase + 1) % 16;
    end
  end

  // check every result transaction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      board.check_result(out_ch.entity_index, out_ch.last_of_run, out_ch.empty_set);
  end

  // watchdog on cycles with no transaction on either channel
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/sdos_pkg.sv
rtl/sdos_ifs.sv
rtl/sdos_ram.sv
rtl/sdos_ctrl.sv
rtl/stable_depth_order_sorter.sv
tb/sv/tb_top.sv
